FILE: hdl/board_tile_distance_assert.svh
// Assertion macros for the tile distance block.
`ifndef BOARD_TILE_DISTANCE_ASSERT_SVH
`define BOARD_TILE_DISTANCE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define BDT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define BDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bdt_pkg.sv
// Shared types and constants of the tile distance block.
`timescale 1ns / 1ps
`default_nettype none

package bdt_pkg;

  localparam int POS_W    = 8;
  localparam int ROW_W    = POS_W - 1;
  localparam int SQ_W     = 2 * ROW_W + 1;
  localparam int SUM_W    = 21;
  localparam int DIM_W    = 5;
  localparam int METRIC_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_DIM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_METRIC    = 1'b1;

  localparam logic [METRIC_W-1:0] METRIC_EUCLID    = 2'd0;
  localparam logic [METRIC_W-1:0] METRIC_MANHATTAN = 2'd1;
  localparam logic [METRIC_W-1:0] METRIC_HAMMING   = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET    = 5'd3;
  localparam logic [DIM_W-1:0] DIM_MIN      = 5'd2;
  localparam logic [METRIC_W-1:0] METRIC_RESET = METRIC_MANHATTAN;

  typedef struct packed {
    logic [ROW_W-1:0] dx;
    logic [ROW_W-1:0] dy;
    logic             neq;
    logic             last;
  } tile_t;

endpackage

`default_nettype wire

FILE: hdl/bdt_in_if.sv
// Input request channel: one tile's cell indices on both boards.
`timescale 1ns / 1ps
`default_nettype none

interface bdt_in_if import bdt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pos_a;
  logic [POS_W-1:0] pos_b;
  logic             last;

  modport source (output valid, output pos_a, output pos_b, output last, input ready);
  modport sink (input valid, input pos_a, input pos_b, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/bdt_out_if.sv
// Result request channel: total distance of a board pair.
`timescale 1ns / 1ps
`default_nettype none

interface bdt_out_if import bdt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink (input valid, input distance, output ready);
endinterface

`default_nettype wire

FILE: hdl/bdt_front.sv
// Front end: accept a tile, split both indices into row and column, queue the deltas.
`timescale 1ns / 1ps
`default_nettype none

module bdt_front import bdt_pkg::*; #(
  parameter int MAX_DIM = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [DIM_W-1:0] board_dim,
  bdt_in_if.sink                in_tile,
  output tile_t                 push_data,
  output logic                  push,
  input  wire logic             full
);

  localparam int DIV_W = $clog2(MAX_DIM + 1);
  localparam int CNT_W = $clog2(POS_W);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t          state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] side_r;
  logic [POS_W-1:0] dvd_a_r, dvd_b_r;
  logic [DIV_W-1:0] rem_a_r, rem_b_r;
  logic             neq_r;
  logic             last_r;

  logic [DIV_W-1:0] side_nxt;
  logic [DIV_W:0]   trial_a, trial_b;
  logic             ge_a, ge_b;
  logic [DIV_W-1:0] rem_a_nxt, rem_b_nxt;
  logic [DIV_W-1:0] dcol;
  logic [POS_W-1:0] drow;

  always_comb begin
    if (board_dim < DIM_MIN) begin
      side_nxt = DIV_W'(DIM_MIN);
    end else if (board_dim > DIM_W'(MAX_DIM)) begin
      side_nxt = DIV_W'(MAX_DIM);
    end else begin
      side_nxt = DIV_W'(board_dim);
    end
  end

  always_comb begin
    trial_a   = {rem_a_r, dvd_a_r[POS_W-1]};
    trial_b   = {rem_b_r, dvd_b_r[POS_W-1]};
    ge_a      = trial_a >= {1'b0, side_r};
    ge_b      = trial_b >= {1'b0, side_r};
    rem_a_nxt = ge_a ? DIV_W'(trial_a - {1'b0, side_r}) : DIV_W'(trial_a);
    rem_b_nxt = ge_b ? DIV_W'(trial_b - {1'b0, side_r}) : DIV_W'(trial_b);
  end

  always_comb begin
    dcol = (rem_a_r >= rem_b_r) ? (rem_a_r - rem_b_r) : (rem_b_r - rem_a_r);
    drow = (dvd_a_r >= dvd_b_r) ? (dvd_a_r - dvd_b_r) : (dvd_b_r - dvd_a_r);
    push_data.dx   = ROW_W'(dcol);
    push_data.dy   = drow[ROW_W-1:0];
    push_data.neq  = neq_r;
    push_data.last = last_r;
  end

  assign push          = (state_r == F_PUSH) && !full;
  assign in_tile.ready = (state_r == F_IDLE) && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_tile.valid) begin
            side_r  <= side_nxt;
            dvd_a_r <= in_tile.pos_a;
            dvd_b_r <= in_tile.pos_b;
            rem_a_r <= '0;
            rem_b_r <= '0;
            neq_r   <= in_tile.pos_a != in_tile.pos_b;
            last_r  <= in_tile.last;
            cnt_r   <= CNT_W'(POS_W - 1);
            state_r <= F_DIV;
          end
        end
        F_DIV: begin
          rem_a_r <= rem_a_nxt;
          rem_b_r <= rem_b_nxt;
          dvd_a_r <= {dvd_a_r[POS_W-2:0], ge_a};
          dvd_b_r <= {dvd_b_r[POS_W-2:0], ge_b};
          cnt_r   <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bdt_fifo.sv
// Two-entry queue of tile deltas between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module bdt_fifo import bdt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  tile_t     push_data,
  output logic      full,
  input  wire logic pop,
  output tile_t     pop_data,
  output logic      avail
);

  tile_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;

  assign full     = count_r == (Q_PTR_W + 1)'(Q_DEPTH);
  assign avail    = count_r != '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bdt_back.sv
// Back end: form the tile term (bit-serial root for Euclidean), accumulate, emit total.
`timescale 1ns / 1ps
`default_nettype none

module bdt_back import bdt_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [METRIC_W-1:0] metric,
  input  tile_t                    pop_data,
  input  wire logic                avail,
  output logic                     pop,
  bdt_out_if.source                out_total
);

  localparam int RT_W  = (SQ_W + 2 * FRACTION_BITS + 1) / 2;
  localparam int RAD_W = 2 * RT_W;
  localparam int CNT_W = $clog2(RT_W);

  typedef enum logic [1:0] {B_IDLE, B_ROOT, B_ADD} bstate_t;

  bstate_t          state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [RAD_W-1:0] rad_r;
  logic [RT_W:0]    rem_r;
  logic [RT_W-1:0]  root_r;
  logic [SUM_W-1:0] term_r;
  logic [SUM_W-1:0] sum_r;
  logic             last_r;
  logic             out_valid_r;
  logic [SUM_W-1:0] distance_r;

  logic [SQ_W-1:0]  sq;
  logic [RT_W+2:0]  rem_t;
  logic [RT_W+2:0]  trial;
  logic             take;
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sum_sat;
  logic             out_free;
  logic             emit;

  always_comb begin
    sq = SQ_W'(pop_data.dx) * SQ_W'(pop_data.dx) + SQ_W'(pop_data.dy) * SQ_W'(pop_data.dy);
  end

  always_comb begin
    rem_t = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial = (RT_W + 3)'({root_r, 2'b01});
    take  = rem_t >= trial;
  end

  always_comb begin
    sum_ext = {1'b0, sum_r} + {1'b0, term_r};
    sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
  end

  assign out_free           = !out_valid_r || out_total.ready;
  assign emit               = (state_r == B_ADD) && last_r && out_free;
  assign pop                = (state_r == B_IDLE) && avail;
  assign out_total.valid    = out_valid_r;
  assign out_total.distance = distance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_total.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (avail) begin
            last_r <= pop_data.last;
            unique case (metric)
              METRIC_EUCLID: begin
                rad_r   <= RAD_W'(sq) << (2 * FRACTION_BITS);
                rem_r   <= '0;
                root_r  <= '0;
                cnt_r   <= CNT_W'(RT_W - 1);
                state_r <= B_ROOT;
              end
              METRIC_MANHATTAN: begin
                term_r  <= SUM_W'({1'b0, pop_data.dx} + {1'b0, pop_data.dy}) << FRACTION_BITS;
                state_r <= B_ADD;
              end
              default: begin
                term_r  <= SUM_W'(pop_data.neq) << FRACTION_BITS;
                state_r <= B_ADD;
              end
            endcase
          end
        end
        B_ROOT: begin
          rad_r  <= rad_r << 2;
          rem_r  <= take ? (RT_W + 1)'(rem_t - trial) : (RT_W + 1)'(rem_t);
          root_r <= {root_r[RT_W-2:0], take};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            term_r  <= SUM_W'({root_r[RT_W-2:0], take});
            state_r <= B_ADD;
          end
        end
        B_ADD: begin
          if (!last_r) begin
            sum_r   <= sum_sat;
            state_r <= B_IDLE;
          end else if (out_free) begin
            distance_r <= sum_sat;
            sum_r      <= '0;
            state_r    <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/board_tile_distance.sv
// Each request carries one tile's cell index on two square boards; the block splits both
// indices into row and column by a restoring divide (one quotient bit per cycle) in the front
// end, queues the deltas, and the back end adds one term per tile to a saturating sum with
// FRACTION_BITS fraction bits, emitting the total on the tile marked last.
// The front end takes a new tile only once the last one is pushed, and the back end pops a
// new tile only once the last term is added. A Euclidean tile holds the back end longer, in
// the bit-serial square root that resolves one root bit per cycle. Sustained rate is the
// slower of the two halves. A two-entry queue between the halves and the result register
// let input be taken while a total waits.
`timescale 1ns / 1ps
`default_nettype none

`include "board_tile_distance_assert.svh"

module board_tile_distance import bdt_pkg::*; #(
  parameter int MAX_DIM       = 16,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  bdt_in_if.sink                    in_tile,
  bdt_out_if.source                 out_total,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [DIM_W-1:0]     cfg_wdata
);

  logic [DIM_W-1:0]    board_dim_r;
  logic [METRIC_W-1:0] metric_r;

  tile_t push_data;
  tile_t pop_data;
  logic  push, full, pop, avail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_dim_r <= DIM_RESET;
      metric_r    <= METRIC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_BOARD_DIM: board_dim_r <= cfg_wdata;
        CFG_METRIC:    metric_r    <= cfg_wdata[METRIC_W-1:0];
        default: ;
      endcase
    end
  end

  bdt_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .board_dim (board_dim_r),
    .in_tile   (in_tile),
    .push_data (push_data),
    .push      (push),
    .full      (full)
  );

  bdt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .avail     (avail)
  );

  bdt_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .metric    (metric_r),
    .pop_data  (pop_data),
    .avail     (avail),
    .pop       (pop),
    .out_total (out_total)
  );

  `BDT_ASSERT_SAME(a_no_push_full, clk, rst_n, push, !full, "push into full queue")
  `BDT_ASSERT_SAME(a_no_pop_empty, clk, rst_n, pop, avail, "pop from empty queue")
  `BDT_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_tile.valid && in_tile.ready, !in_tile.ready, "front ready while dividing")

endmodule

`default_nettype wire
